// ----- rtl/pcmrs_pkg.sv -----
// Package: shared types and constants of the PCM rate, channel and width converter.
`timescale 1ns / 1ps
package pcmrs_pkg;

  localparam int MAX_CHANNELS_DEF      = 8;
  localparam int MAX_PACKET_FRAMES_DEF = 4096;
  localparam int RESULT_LIMIT          = 64;
  localparam int CFG_IDX_W             = 3;
  localparam int CFG_DATA_W            = 18;

  localparam logic [17:0] IN_RATE_RST  = 18'd48000;
  localparam logic [3:0]  IN_CH_RST    = 4'd2;
  localparam logic [1:0]  IN_BPS_RST   = 2'd2;
  localparam logic [17:0] OUT_RATE_RST = 18'd48000;
  localparam logic [3:0]  OUT_CH_RST   = 4'd2;
  localparam logic [1:0]  OUT_BPS_RST  = 2'd2;
  localparam logic [12:0] PKT_FR_RST   = 13'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_RATE       = 3'd0,
    REG_IN_CHANNELS   = 3'd1,
    REG_IN_BPS        = 3'd2,
    REG_OUT_RATE      = 3'd3,
    REG_OUT_CHANNELS  = 3'd4,
    REG_OUT_BPS       = 3'd5,
    REG_PACKET_FRAMES = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               packet_end;
    logic               run_last;
  } out_word_t;

  typedef struct packed {
    logic [17:0] in_rate;
    logic [3:0]  src_chans;
    logic [1:0]  in_bytes_per_sample;
    logic [17:0] dst_rate;
    logic [3:0]  dst_chans;
    logic [1:0]  out_bytes_per_sample;
    logic [12:0] pkt_len;
  } cfg_t;

  typedef enum logic [1:0] {
    K_DATA = 2'd0,
    K_END  = 2'd1,
    K_DROP = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
  } q_word_t;

endpackage

// ----- rtl/pcmrs_ram.sv -----
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module pcmrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- rtl/pcmrs_front.sv -----
// Front end: accepts input words, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module pcmrs_front import pcmrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_stall,
  input  in_word_t src_word,
  input  logic     pf_zero,
  output logic     q_valid,
  input  logic     q_pop,
  output q_word_t  q_word
);
  q_word_t    slots [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push;
  q_word_t    cls;

  assign src_stall = (count == 2'd2);
  assign push      = src_valid && !src_stall;
  assign q_valid   = (count != 2'd0);
  assign q_word    = slots[rp];

  always_comb begin
    cls.data_byte = src_word.data_byte;
    if (src_word.opcode) begin
      cls.kind = K_END;
    end else if (pf_zero) begin
      cls.kind = K_DROP;
    end else begin
      cls.kind = K_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= cls;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end
endmodule

// ----- rtl/pcmrs_back.sv -----
// Back end: stores input bytes, maps frames and channels, and emits output words.
`timescale 1ns / 1ps
module pcmrs_back import pcmrs_pkg::*; #(
  parameter int MAX_CHANNELS      = MAX_CHANNELS_DEF,
  parameter int MAX_PACKET_FRAMES = MAX_PACKET_FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cfg_we,
  input  logic      q_valid,
  output logic      q_pop,
  input  q_word_t   q_word,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_word_t dst_word
);
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SB    = 2 * MAX_CHANNELS;
  localparam int SA_W  = $clog2(SB);
  localparam int FB_W  = CNT_W + 1;
  localparam int PF_W  = $clog2(MAX_PACKET_FRAMES + 1);
  localparam int PR_W  = 50;
  localparam int GI_W  = PR_W + CNT_W;
  localparam int GP_W  = GI_W + 2;
  localparam int RL_W  = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_MOD   = 11'b00000000010,
    S_WR    = 11'b00000000100,
    S_NORM  = 11'b00000001000,
    S_PREP  = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_DIV   = 11'b00001000000,
    S_GMUL  = 11'b00010000000,
    S_CHECK = 11'b00100000000,
    S_VAL   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t            state;
  logic [31:0]       br, f, msh;
  logic [CI_W-1:0]   idx;
  logic [PF_W-1:0]   fill;
  logic              ginv;
  logic [FB_W-1:0]   mrem;
  logic [4:0]        mcnt;
  logic [PR_W-1:0]   qsh;
  logic [17:0]       drem;
  logic [5:0]        dcnt;
  logic [GI_W-1:0]   gich;
  logic [RL_W-1:0]   cnt;
  logic              pend, fin;
  logic [15:0]       cand;
  logic              cand_pend;
  logic [15:0]       held;
  logic              held_pend, hvalid;
  logic [7:0]        wbyte;

  logic [17:0]       irate, orate;
  logic [CNT_W-1:0]  ich, och;
  logic              ibps2, out8;
  logic [PF_W-1:0]   pfr;
  logic [FB_W-1:0]   fb;
  logic [FB_W:0]     mt, mt_red;
  logic [18:0]       dt;
  logic              dge;
  logic [CI_W-1:0]   ch;
  logic [GP_W-1:0]   pos, need;
  logic [SA_W-1:0]   off, off1;
  logic [7:0]        rd0, rd1;
  logic [15:0]       v16, vout;
  logic              idx_ge, last_ch, fill_full;
  logic [CNT_W:0]    idx_inc;
  logic [PF_W:0]     fill_inc;
  logic              slot_free;
  logic              send, ginv_set, ginv_clr;

  always_comb begin
    irate = (cfg.in_rate == 18'd0) ? 18'd1 : cfg.in_rate;
    orate = (cfg.dst_rate == 18'd0) ? 18'd1 : cfg.dst_rate;
    if (cfg.src_chans == 4'd0) ich = CNT_W'(1);
    else if (int'(cfg.src_chans) > MAX_CHANNELS) ich = CNT_W'(MAX_CHANNELS);
    else ich = CNT_W'(cfg.src_chans);
    if (cfg.dst_chans == 4'd0) och = CNT_W'(1);
    else if (int'(cfg.dst_chans) > MAX_CHANNELS) och = CNT_W'(MAX_CHANNELS);
    else och = CNT_W'(cfg.dst_chans);
    ibps2 = (cfg.in_bytes_per_sample != 2'd1);
    out8  = (cfg.out_bytes_per_sample == 2'd1);
    if (int'(cfg.pkt_len) > MAX_PACKET_FRAMES) pfr = PF_W'(MAX_PACKET_FRAMES);
    else pfr = PF_W'(cfg.pkt_len);
    fb = ibps2 ? {ich, 1'b0} : {1'b0, ich};

    // one remainder bit per cycle for the store address
    mt     = {mrem, msh[31]};
    mt_red = (mt >= (FB_W + 1)'(fb)) ? mt - (FB_W + 1)'(fb) : mt;
    dt     = {drem, qsh[PR_W-1]};
    dge    = (dt >= {1'b0, orate});

    idx_ge   = (CNT_W'(idx) >= och);
    ch       = (CNT_W'(idx) < ich) ? idx : CI_W'(ich - CNT_W'(1));
    pos      = (GP_W'(gich) + GP_W'(ch)) << ibps2;
    need     = pos + (ibps2 ? GP_W'(2) : GP_W'(1));
    idx_inc  = (CNT_W + 1)'(idx) + (CNT_W + 1)'(1);
    last_ch  = (idx_inc >= (CNT_W + 1)'(och));
    fill_inc = (PF_W + 1)'(fill) + (PF_W + 1)'(1);
    fill_full = (fill_inc >= (PF_W + 1)'(pfr));
    off      = SA_W'(ch) << ibps2;
    off1     = off + SA_W'(1);

    v16  = ibps2 ? {rd1, rd0} : {rd0, 8'h00};
    vout = out8 ? {{8{v16[15]}}, v16[15:8]} : v16;
    slot_free = !dst_valid || !dst_stall;
    send      = (state == S_EMIT) && hvalid && slot_free;

    // frame index goes stale on a new frame, an end word or a register write
    ginv_set = cfg_we ||
               ((state == S_IDLE) && q_valid && (q_word.kind == K_END)) ||
               ((state == S_NORM) && (cnt != RL_W'(RESULT_LIMIT)) && idx_ge) ||
               ((state == S_CHECK) && !(need > GP_W'(br)) && last_ch);
    ginv_clr = (state == S_GMUL);
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  pcmrs_ram #(.WIDTH(8), .DEPTH(SB)) u_store (
    .clk     (clk),
    .we      (state == S_WR),
    .waddr   (mrem[SA_W-1:0]),
    .wdata   (wbyte),
    .raddr_a (off),
    .raddr_b (off1),
    .rdata_a (rd0),
    .rdata_b (rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      br        <= '0;
      f         <= '0;
      idx       <= '0;
      fill      <= '0;
      ginv      <= 1'b1;
      hvalid    <= 1'b0;
      dst_valid <= 1'b0;
      cnt       <= '0;
      fin       <= 1'b0;
    end else begin
      if (send) dst_valid <= 1'b1;
      else if (!dst_stall) dst_valid <= 1'b0;
      if (ginv_set) ginv <= 1'b1;
      else if (ginv_clr) ginv <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_word.kind)
              K_END: begin
                br   <= '0;
                f    <= '0;
                idx  <= '0;
                fill <= '0;
              end
              K_DATA: begin
                wbyte <= q_word.data_byte;
                mrem  <= '0;
                msh   <= br;
                mcnt  <= '0;
                state <= S_MOD;
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          mrem <= mt_red[FB_W-1:0];
          msh  <= {msh[30:0], 1'b0};
          mcnt <= mcnt + 5'd1;
          if (mcnt == 5'd31) state <= S_WR;
        end
        S_WR: begin
          br    <= br + 32'd1;
          cnt   <= '0;
          fin   <= 1'b0;
          state <= S_NORM;
        end
        S_NORM: begin
          if (cnt == RL_W'(RESULT_LIMIT)) begin
            fin   <= 1'b1;
            state <= S_EMIT;
          end else begin
            if (idx_ge) begin
              idx  <= '0;
              f    <= f + 32'd1;
            end
            state <= S_PREP;
          end
        end
        S_PREP: state <= ginv ? S_MUL : S_CHECK;
        S_MUL: begin
          qsh   <= PR_W'(f) * PR_W'(irate);
          drem  <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          drem <= dge ? 18'(dt - {1'b0, orate}) : dt[17:0];
          qsh  <= {qsh[PR_W-2:0], dge};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(PR_W - 1)) state <= S_GMUL;
        end
        S_GMUL: begin
          gich  <= GI_W'(qsh) * GI_W'(ich);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (need > GP_W'(br)) begin
            fin   <= 1'b1;
            state <= S_EMIT;
          end else begin
            pend <= 1'b0;
            if (last_ch) begin
              if (fill_full) begin
                pend <= 1'b1;
                fill <= '0;
              end else begin
                fill <= fill_inc[PF_W-1:0];
              end
              idx  <= '0;
              f    <= f + 32'd1;
            end else begin
              idx <= CI_W'(idx_inc);
            end
            cnt   <= cnt + RL_W'(1);
            state <= S_VAL;
          end
        end
        S_VAL: begin
          cand      <= vout;
          cand_pend <= pend;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          // one sample is held back so the last of a run can be marked
          if (fin) begin
            if (!hvalid) begin
              state <= S_IDLE;
            end else if (slot_free) begin
              dst_word  <= '{sample_value: held, packet_end: held_pend, run_last: 1'b1};
              hvalid    <= 1'b0;
              state     <= S_IDLE;
            end
          end else if (!hvalid) begin
            held      <= cand;
            held_pend <= cand_pend;
            hvalid    <= 1'b1;
            state     <= S_NORM;
          end else if (slot_free) begin
            dst_word  <= '{sample_value: held, packet_end: held_pend, run_last: 1'b0};
            held      <= cand;
            held_pend <= cand_pend;
            state     <= S_NORM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/pcm_resample_channel_map_packetizer.sv -----
// Top level: configuration registers, input queue front end and conversion engine.
`timescale 1ns / 1ps
// Nearest-neighbor PCM rate, channel and width converter with packet marks. Raw
// interleaved little-endian PCM enters one byte per word; output frame f takes
// input frame floor(f * input rate / output rate). A data byte passes through the
// engine as accept, a 32-step remainder for its store slot and the write, then
// emits samples and closes the run; each new output frame also runs the 50-step
// frame-index divider. A stalled output holds the engine in its emit state. End
// and dropped words are taken in the idle state. A two-word queue in front keeps
// input flowing while the engine or the output is busy, until both slots fill.
module pcm_resample_channel_map_packetizer import pcmrs_pkg::*; #(
  parameter int MAX_CHANNELS      = MAX_CHANNELS_DEF,
  parameter int MAX_PACKET_FRAMES = MAX_PACKET_FRAMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  src_valid,
  output logic                  src_stall,
  input  in_word_t              src_word,
  output logic                  dst_valid,
  input  logic                  dst_stall,
  output out_word_t             dst_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  cfg_t    cfg;
  logic    q_valid, q_pop;
  q_word_t q_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_rate              <= IN_RATE_RST;
      cfg.src_chans            <= IN_CH_RST;
      cfg.in_bytes_per_sample  <= IN_BPS_RST;
      cfg.dst_rate             <= OUT_RATE_RST;
      cfg.dst_chans            <= OUT_CH_RST;
      cfg.out_bytes_per_sample <= OUT_BPS_RST;
      cfg.pkt_len              <= PKT_FR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_RATE:       cfg.in_rate              <= cfg_data;
        REG_IN_CHANNELS:   cfg.src_chans            <= cfg_data[3:0];
        REG_IN_BPS:        cfg.in_bytes_per_sample  <= cfg_data[1:0];
        REG_OUT_RATE:      cfg.dst_rate             <= cfg_data;
        REG_OUT_CHANNELS:  cfg.dst_chans            <= cfg_data[3:0];
        REG_OUT_BPS:       cfg.out_bytes_per_sample <= cfg_data[1:0];
        REG_PACKET_FRAMES: cfg.pkt_len              <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  pcmrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .pf_zero   (cfg.pkt_len == 13'd0),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_word    (q_word)
  );

  pcmrs_back #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .MAX_PACKET_FRAMES (MAX_PACKET_FRAMES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_we    (cfg_we),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_word    (q_word),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_word  (dst_word)
  );
endmodule
